// ----- src/one_wire_bus_master_defines.svh -----
// Assertion macros shared by the one-wire bus master RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define OWBM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define OWBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/owbm_pkg.sv -----
// Shared types and constants of the one-wire bus master.
// No dependencies; used by the interfaces and all modules.
package owbm_pkg;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_UNIT_TICKS = 1'b0;
  localparam logic [15:0] UNIT_TICKS_RST = 16'd12;

  localparam logic [6:0] RST_REL_UNITS  = 7'd12;
  localparam logic [6:0] RST_LOW_UNITS  = 7'd80;
  localparam logic [6:0] RST_WAIT_UNITS = 7'd10;
  localparam logic [6:0] TAIL_UNITS     = 7'd5;
  localparam logic [6:0] BIT_UNITS      = 7'd5;
  localparam logic [2:0] LAST_BIT       = 3'd7;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       line_level;
  } cmd_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       no_device;
    logic       rejected;
  } res_item_t;

endpackage

// ----- src/owbm_cmd_if.sv -----
// Command channel of the one-wire bus master: valid/ready plus one tick item.
// Depends on owbm_pkg.
interface owbm_cmd_if import owbm_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ----- src/owbm_res_if.sv -----
// Result channel of the one-wire bus master: valid/ready plus one result item.
// Depends on owbm_pkg.
interface owbm_res_if import owbm_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ----- src/owbm_cfg.sv -----
// APB register block of the one-wire bus master: holds unit_ticks.
// Depends on owbm_pkg.
module owbm_cfg import owbm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [15:0]        unit_ticks
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1] == REG_UNIT_TICKS);

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_TICKS_RST;
    end else if (psel && penable && pwrite && pready && hit) begin
      unit_ticks <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(PDATA_W-16){1'b0}}, unit_ticks};
    end
  end

endmodule

// ----- src/owbm_core.sv -----
// Bus timing sequencer: advances one tick per accepted command transaction.
// Depends on owbm_pkg and one_wire_bus_master_defines.svh.
`include "one_wire_bus_master_defines.svh"

module owbm_core import owbm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  cmd_item_t cmd,
  input  logic [15:0] unit_ticks,
  output res_item_t res
);

  typedef enum logic [12:0] {
    PH_IDLE     = 13'b0000000000001,
    PH_RST_REL  = 13'b0000000000010,
    PH_RST_LOW  = 13'b0000000000100,
    PH_RST_WAIT = 13'b0000000001000,
    PH_RST_SAMP = 13'b0000000010000,
    PH_RST_TAIL = 13'b0000000100000,
    PH_WR_LOW   = 13'b0000001000000,
    PH_WR_DRIVE = 13'b0000010000000,
    PH_WR_GAP   = 13'b0000100000000,
    PH_WR_TAIL  = 13'b0001000000000,
    PH_RD_LOW   = 13'b0010000000000,
    PH_RD_SAMP  = 13'b0100000000000,
    PH_RD_WAIT  = 13'b1000000000000
  } phase_t;

  typedef struct packed {
    logic        fin;
    logic [6:0]  uc;
    logic [15:0] tc;
  } cnt_t;

  phase_t      phase, phase_next;
  logic [6:0]  unit_count, unit_count_next;
  logic [15:0] tick_count, tick_count_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic        presence_fail, presence_fail_next;
  logic [7:0]  last_read, last_read_next;
  logic [15:0] len;
  cnt_t        cnt;
  logic        drive, done, rej;

  function automatic cnt_t count_units(logic [15:0] tc, logic [6:0] uc,
                                       logic [15:0] ln, logic [6:0] n);
    cnt_t       r;
    logic [15:0] tc1;
    logic [6:0]  uc1;
    tc1   = tc + 16'd1;
    uc1   = uc + 7'd1;
    r.fin = 1'b0;
    r.uc  = uc;
    r.tc  = tc1;
    if (tc1 >= ln) begin
      r.tc = '0;
      r.uc = uc1;
      if (uc1 >= n) begin
        r.uc  = '0;
        r.fin = 1'b1;
      end
    end
    return r;
  endfunction

  assign len = (unit_ticks == 16'd0) ? 16'd1 : unit_ticks;

  always_comb begin
    phase_next         = phase;
    unit_count_next    = unit_count;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_fail_next = presence_fail;
    last_read_next     = last_read;
    drive = 1'b0;
    done  = 1'b0;
    rej   = 1'b0;
    cnt   = '0;

    if (phase != PH_IDLE) begin
      rej = (cmd.opcode != OP_TICK);
    end else if (cmd.opcode != OP_TICK) begin
      bit_index_next  = '0;
      unit_count_next = '0;
      tick_count_next = '0;
      case (cmd.opcode)
        OP_RESET: phase_next = PH_RST_REL;
        OP_WRITE: begin
          shift_byte_next = cmd.data_byte;
          phase_next      = PH_WR_LOW;
        end
        default: begin
          shift_byte_next = '0;
          phase_next      = PH_RD_LOW;
        end
      endcase
    end

    res.busy_res = (phase_next != PH_IDLE);

    case (phase_next)
      PH_IDLE: ;
      PH_RST_REL: begin
        cnt = count_units(tick_count_next, unit_count_next, len, RST_REL_UNITS);
        unit_count_next = cnt.uc;
        tick_count_next = cnt.tc;
        if (cnt.fin) phase_next = PH_RST_LOW;
      end
      PH_RST_LOW: begin
        drive = 1'b1;
        cnt = count_units(tick_count_next, unit_count_next, len, RST_LOW_UNITS);
        unit_count_next = cnt.uc;
        tick_count_next = cnt.tc;
        if (cnt.fin) phase_next = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        cnt = count_units(tick_count_next, unit_count_next, len, RST_WAIT_UNITS);
        unit_count_next = cnt.uc;
        tick_count_next = cnt.tc;
        if (cnt.fin) phase_next = PH_RST_SAMP;
      end
      PH_RST_SAMP: begin
        presence_fail_next = cmd.line_level;
        phase_next      = PH_RST_TAIL;
        unit_count_next = '0;
        tick_count_next = '0;
      end
      PH_RST_TAIL: begin
        cnt = count_units(tick_count_next, unit_count_next, len, TAIL_UNITS);
        unit_count_next = cnt.uc;
        tick_count_next = cnt.tc;
        if (cnt.fin) begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
      end
      PH_WR_LOW: begin
        drive = 1'b1;
        phase_next      = PH_WR_DRIVE;
        unit_count_next = '0;
        tick_count_next = '0;
      end
      PH_WR_DRIVE: begin
        drive = ~shift_byte_next[0];
        cnt = count_units(tick_count_next, unit_count_next, len, BIT_UNITS);
        unit_count_next = cnt.uc;
        tick_count_next = cnt.tc;
        if (cnt.fin) begin
          shift_byte_next = {1'b0, shift_byte_next[7:1]};
          if (bit_index_next == LAST_BIT) begin
            bit_index_next = '0;
            phase_next     = PH_WR_TAIL;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next     = PH_WR_GAP;
          end
        end
      end
      PH_WR_GAP: begin
        phase_next      = PH_WR_LOW;
        unit_count_next = '0;
        tick_count_next = '0;
      end
      PH_WR_TAIL: begin
        cnt = count_units(tick_count_next, unit_count_next, len, TAIL_UNITS);
        unit_count_next = cnt.uc;
        tick_count_next = cnt.tc;
        if (cnt.fin) begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
      end
      PH_RD_LOW: begin
        drive = 1'b1;
        phase_next      = PH_RD_SAMP;
        unit_count_next = '0;
        tick_count_next = '0;
      end
      PH_RD_SAMP: begin
        shift_byte_next = {cmd.line_level, shift_byte_next[7:1]};
        phase_next      = PH_RD_WAIT;
        unit_count_next = '0;
        tick_count_next = '0;
      end
      PH_RD_WAIT: begin
        cnt = count_units(tick_count_next, unit_count_next, len, BIT_UNITS);
        unit_count_next = cnt.uc;
        tick_count_next = cnt.tc;
        if (cnt.fin) begin
          if (bit_index_next == LAST_BIT) begin
            bit_index_next = '0;
            last_read_next = shift_byte_next;
            phase_next     = PH_IDLE;
            done           = 1'b1;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next     = PH_RD_LOW;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        unit_count_next = '0;
        tick_count_next = '0;
      end
    endcase

    res.drive_low = drive;
    res.done_res  = done;
    res.read_byte = last_read_next;
    res.no_device = presence_fail_next;
    res.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      unit_count    <= '0;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_fail <= 1'b0;
      last_read     <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      unit_count    <= unit_count_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_fail <= presence_fail_next;
      last_read     <= last_read_next;
    end
  end

  `OWBM_ASSERT_NEXT(a_done_ends_idle, clk, rst, fire && res.done_res, phase == PH_IDLE,
    "operation completed but sequencer did not return to idle")
  `OWBM_ASSERT_SAME(a_reject_only_busy, clk, rst, fire && res.rejected, phase != PH_IDLE,
    "command rejected while sequencer was idle")
  `OWBM_ASSERT_SAME(a_drive_needs_busy, clk, rst, fire && res.drive_low, res.busy_res,
    "bus driven low outside an operation")
  `OWBM_ASSERT_NEXT(a_hold_without_fire, clk, rst, !fire, $stable(phase) && $stable(tick_count),
    "sequencer advanced without a command transaction")

endmodule

// ----- src/one_wire_bus_master.sv -----
// One-wire bus master: each command transaction is one bus clock tick and
// carries an optional command (bus reset with presence check, write byte,
// read byte) plus the sampled line level. Each tick yields one result
// transaction on res: drive_low for the bus pad, busy/done flags, the last
// read byte, the presence result and a rejected flag for commands that
// arrive while an operation runs.
// The result of a tick is registered and appears on res in the cycle after
// the command transaction. Throughput: one tick per cycle while res is not
// stalled; the sequencer state and the result register are the only stages.
// Reset (rst, synchronous) returns the sequencer to idle, clears the read
// byte and presence flag and loads unit_ticks with 12.
// When res is stalled, the result register holds and cmd.ready drops until
// the pending result is taken; it stays high while the result is taken in
// the same cycle. unit_ticks is written through the APB port at byte
// address 0 and should be changed only while no operation is in progress.
// Depends on owbm_pkg, owbm_cmd_if, owbm_res_if, owbm_cfg and owbm_core.
module one_wire_bus_master import owbm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  owbm_cmd_if.sink           cmd,
  owbm_res_if.source         res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [15:0] unit_ticks;
  logic        fire;
  logic        res_valid;
  res_item_t   res_item;
  res_item_t   res_comb;

  owbm_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .unit_ticks (unit_ticks)
  );

  owbm_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .cmd        (cmd.item),
    .unit_ticks (unit_ticks),
    .res        (res_comb)
  );

  assign cmd.ready = !res_valid || res.ready;
  assign fire      = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.ready) begin
      res_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_item <= res_comb;
    end
  end

  assign res.valid = res_valid;
  assign res.item  = res_item;

endmodule
